/* hdl/frma_pkg.sv */
// Package for the frame rate moving average core.
// Holds payload structs, divider request/response types, register indexes and widths.
// No dependencies.
package frma_pkg;

    localparam int RATE_W     = 26;
    localparam int PERIOD_W   = 32;
    localparam int TPS_W      = 30;
    localparam int MAXR_W     = 10;
    localparam int COUNT_O_W  = 7;
    localparam int FRAC_W     = 16;
    localparam int DIV_N      = TPS_W + FRAC_W;
    localparam int DIV_D      = PERIOD_W;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 30;

    localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_SECOND = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_RATE         = 1'd1;

    localparam logic [TPS_W-1:0]  TPS_RESET  = TPS_W'(1000000);
    localparam logic [MAXR_W-1:0] MAXR_RESET = MAXR_W'(1000);

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    typedef struct packed {
        logic                command;
        logic [PERIOD_W-1:0] frame_period;
    } t_in;

    typedef struct packed {
        logic                 accepted;
        logic [RATE_W-1:0]    current_rate;
        logic [RATE_W-1:0]    average_rate;
        logic [COUNT_O_W-1:0] sample_count;
    } t_out;

    typedef struct packed {
        logic             start;
        logic [DIV_N-1:0] dividend;
        logic [DIV_D-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic             done;
        logic [DIV_N-1:0] quotient;
    } t_div_rsp;

endpackage

/* hdl/frma_div.sv */
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on frma_pkg for widths and request/response structs.
module frma_div
    import frma_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    localparam int CNT_W = $clog2(DIV_N + 1);

    logic [DIV_D-1:0] r_rem;
    logic [DIV_N-1:0] r_quo;
    logic [DIV_D-1:0] r_div;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;

    logic [DIV_D:0]   trial;
    logic [DIV_D:0]   diff;
    logic             ge;
    logic [DIV_D-1:0] n_rem;

    always_comb begin
        trial = {r_rem, r_quo[DIV_N-1]};
        diff  = trial - {1'b0, r_div};
        ge    = (trial >= {1'b0, r_div});
        n_rem = ge ? diff[DIV_D-1:0] : trial[DIV_D-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_N);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_div <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[DIV_N-2:0], ge};
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

/* hdl/frame_rate_moving_average_core.sv */
// Frame rate moving average core: top level with sequencer, history ring and output register.
// Depends on frma_pkg and frma_div.
//
// Input channel (i_in_valid / o_in_ready / i_in_data) carries a command bit and a frame
// period in ticks. Output channel (o_out_valid / i_out_ready / o_out_data) returns one
// result per input: accepted flag, current rate, average rate (10.16) and sample count.
// Configuration channel (i_cfg_valid / o_cfg_ready, index, data) writes ticks_per_second
// (index 0) and max_rate (index 1); it is always ready.
// A sample runs two passes through one shared radix-2 divider of 46 steps: rate =
// (ticks << 16) / period, then mean = sum / count. A clear or a zero period skips the
// divider and goes straight to the output register.
// The divider produces one quotient bit per cycle, 46 bits per pass.
// One item is in work at a time; the input is ready only while the sequencer is idle, so
// a new item is taken only after the output register has loaded the last one's result.
// The output register holds a result until taken; a finished item waits there for it
// while the sequencer returns to idle only after its result has been loaded.
// Reset (synchronous, active low) empties the history, zeroes both rates and restores
// ticks_per_second = 1000000 and max_rate = 1000. The ring needs no clearing pass.
module frame_rate_moving_average_core
    import frma_pkg::*;
#(
    parameter int HISTORY = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in                   i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out                  o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int SLOT_W = (HISTORY > 1) ? $clog2(HISTORY) : 1;
    localparam int CNT_W  = $clog2(HISTORY + 1);
    localparam int SUM_W  = RATE_W + SLOT_W;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SUB  = 3'd1;
    localparam logic [2:0] ST_RATE = 3'd2;
    localparam logic [2:0] ST_MEAN = 3'd3;
    localparam logic [2:0] ST_AVG  = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    logic [2:0]        r_state;
    logic [TPS_W-1:0]  r_tps;
    logic [MAXR_W-1:0] r_maxr;
    logic [SLOT_W-1:0] r_slot;
    logic [CNT_W-1:0]  r_count;
    logic [SUM_W-1:0]  r_sum;
    logic [RATE_W-1:0] r_latest;
    logic [RATE_W-1:0] r_mean;
    logic              r_acc;
    logic              r_out_valid;
    t_out              r_out;
    logic [RATE_W-1:0] r_rd;
    logic [RATE_W-1:0] r_ring [HISTORY];

    logic              in_xfer;
    logic              cfg_xfer;
    logic              out_free;
    logic              full;
    logic [RATE_W-1:0] lim;
    logic [RATE_W-1:0] n_rate;
    logic [SLOT_W-1:0] n_slot;
    t_div_req          div_req;
    t_div_rsp          div_rsp;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign in_xfer     = i_in_valid && o_in_ready;
    assign cfg_xfer    = i_cfg_valid && o_cfg_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign full        = (r_count == CNT_W'(HISTORY));
    assign lim         = {r_maxr, {FRAC_W{1'b0}}};
    assign n_rate      = (div_rsp.quotient > DIV_N'(lim)) ? lim : div_rsp.quotient[RATE_W-1:0];
    assign n_slot      = (r_slot == SLOT_W'(HISTORY - 1)) ? '0 : r_slot + 1'b1;

    always_comb begin
        div_req = '0;
        if (r_state == ST_MEAN) begin
            div_req.start    = 1'b1;
            div_req.dividend = DIV_N'(r_sum);
            div_req.divisor  = DIV_D'(r_count);
        end else begin
            div_req.start    = in_xfer && (i_in_data.command == CMD_SAMPLE)
                               && (i_in_data.frame_period != '0);
            div_req.dividend = {r_tps, {FRAC_W{1'b0}}};
            div_req.divisor  = i_in_data.frame_period;
        end
    end

    frma_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tps  <= TPS_RESET;
            r_maxr <= MAXR_RESET;
        end else if (cfg_xfer) begin
            case (i_cfg_index)
                REG_TICKS_PER_SECOND: r_tps  <= i_cfg_data[TPS_W-1:0];
                REG_MAX_RATE:         r_maxr <= i_cfg_data[MAXR_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd <= r_ring[r_slot];
        if (r_state == ST_RATE && div_rsp.done) begin
            r_ring[r_slot] <= n_rate;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_slot      <= '0;
            r_count     <= '0;
            r_sum       <= '0;
            r_latest    <= '0;
            r_mean      <= '0;
            r_acc       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == ST_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_xfer) begin
                        if (i_in_data.command == CMD_CLEAR) begin
                            r_slot   <= '0;
                            r_count  <= '0;
                            r_sum    <= '0;
                            r_latest <= '0;
                            r_mean   <= '0;
                            r_acc    <= 1'b1;
                            r_state  <= ST_OUT;
                        end else if (i_in_data.frame_period == '0) begin
                            r_acc   <= 1'b0;
                            r_state <= ST_OUT;
                        end else begin
                            r_acc   <= 1'b1;
                            r_state <= ST_SUB;
                        end
                    end
                end
                ST_SUB: begin
                    if (full) begin
                        r_sum <= r_sum - SUM_W'(r_rd);
                    end else begin
                        r_count <= r_count + 1'b1;
                    end
                    r_state <= ST_RATE;
                end
                ST_RATE: begin
                    if (div_rsp.done) begin
                        r_latest <= n_rate;
                        r_sum    <= r_sum + SUM_W'(n_rate);
                        r_slot   <= n_slot;
                        r_state  <= ST_MEAN;
                    end
                end
                ST_MEAN: begin
                    r_state <= ST_AVG;
                end
                ST_AVG: begin
                    if (div_rsp.done) begin
                        r_mean  <= div_rsp.quotient[RATE_W-1:0];
                        r_state <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == ST_OUT && out_free) begin
            r_out.accepted     <= r_acc;
            r_out.current_rate <= r_latest;
            r_out.average_rate <= r_mean;
            r_out.sample_count <= COUNT_O_W'(r_count);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(HISTORY))
        else $error("history count exceeds depth");

    a_slot_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot <= SLOT_W'(HISTORY - 1))
        else $error("write slot out of range");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_rsp.done |-> (r_state == ST_RATE || r_state == ST_AVG))
        else $error("divider finished outside a wait state");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_in_data.command == CMD_CLEAR) |=> (r_count == '0 && r_sum == '0))
        else $error("clear left history state");

endmodule
